[rtl/sbe_pkg.sv]
package sbe_pkg;

	localparam int StackDepth = 256;
	localparam int SpW = $clog2(StackDepth + 1);
	localparam int AddrW = $clog2(StackDepth);
	localparam int DepthW = 9;
	localparam int QueueDepth = 2;

	typedef enum logic [2:0] {
		OP_PUSH_IMM       = 3'd0,
		OP_ADD            = 3'd1,
		OP_SUB            = 3'd2,
		OP_DIV            = 3'd3,
		OP_MUL            = 3'd4,
		OP_POP_TO_RESULT  = 3'd5,
		OP_DONE           = 3'd6,
		OP_UNKNOWN        = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_DONE    = 3'd1,
		ST_DIV0    = 3'd2,
		ST_UNKNOWN = 3'd3,
		ST_UNDER   = 3'd4,
		ST_OVER    = 3'd5
	} status_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] imm;
	} instr_t;

	function automatic op_t decode(input logic [7:0] func);
		op_t o;
		case (func)
			8'd0: o = OP_PUSH_IMM;
			8'd1: o = OP_ADD;
			8'd2: o = OP_SUB;
			8'd3: o = OP_DIV;
			8'd4: o = OP_MUL;
			8'd5: o = OP_POP_TO_RESULT;
			8'd6: o = OP_DONE;
			default: o = OP_UNKNOWN;
		endcase
		return o;
	endfunction

endpackage

[rtl/sbe_front.sv]
module sbe_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid,
	output logic              ready,
	input  logic [7:0]        func,
	input  logic [7:0]        imm,
	output logic              q_valid,
	input  logic              q_ready,
	output sbe_pkg::instr_t   q_instr
);
	localparam int PtrW = $clog2(sbe_pkg::QueueDepth);

	sbe_pkg::instr_t     fifo_q [sbe_pkg::QueueDepth];
	logic [PtrW-1:0]     wr_q, rd_q;
	logic [PtrW:0]       cnt_q;
	logic                push, pop;

	assign ready   = (cnt_q != (PtrW+1)'(sbe_pkg::QueueDepth));
	assign q_valid = (cnt_q != '0);
	assign q_instr = fifo_q[rd_q];
	assign push    = valid && ready;
	assign pop     = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q].op  <= sbe_pkg::decode(func);
			fifo_q[wr_q].imm <= imm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end
endmodule

[rtl/sbe_divider.sv]
module sbe_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        fin,
	output logic [63:0] quotient
);
	logic [63:0] rem_q, quo_q, div_q;
	logic [6:0]  cnt_q;
	logic        busy_q, fin_q;
	logic [64:0] trial;
	logic [64:0] shifted;

	assign shifted  = {rem_q, quo_q[63]};
	assign trial    = shifted - {1'b0, div_q};
	assign fin      = fin_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			// restoring step, one quotient bit per cycle
			if (!trial[64]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted[63:0];
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end
endmodule

[rtl/sbe_back.sv]
module sbe_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_valid,
	output logic                  q_ready,
	input  sbe_pkg::instr_t       q_instr,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [2:0]            status,
	output logic [63:0]           result_value,
	output logic [8:0]            depth
);
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RD1   = 6'b000010,
		S_RD2   = 6'b000100,
		S_EXEC  = 6'b001000,
		S_DIVW  = 6'b010000,
		S_OUT   = 6'b100000
	} state_t;

	localparam logic [sbe_pkg::SpW-1:0] Full = sbe_pkg::SpW'(sbe_pkg::StackDepth);

	state_t                   state_q;
	sbe_pkg::instr_t          ins_q;
	logic [63:0]              mem [sbe_pkg::StackDepth];
	logic [63:0]              rdata_q, r_q, l_q, res_q;
	logic [sbe_pkg::SpW-1:0]  sp_q, sp_eff;
	logic                     ended_q;
	logic [2:0]               st_q;
	logic [63:0]              prod_q;
	logic                     prod_v_q;
	logic                     rd_en, wr_en;
	logic [sbe_pkg::AddrW-1:0] rd_addr, wr_addr;
	logic [63:0]              wr_data;
	logic                     div_start, div_fin;
	logic [63:0]              div_quo;

	// fresh program after an end
	assign sp_eff = ended_q ? '0 : sp_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rdata_q <= mem[rd_addr];
	end

	sbe_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(l_q), .divisor(r_q),
		.fin(div_fin), .quotient(div_quo)
	);

	assign q_ready   = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = st_q;
	assign result_value = res_q;
	assign depth     = sbe_pkg::DepthW'(sp_q);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;
		div_start = 1'b0;
		case (state_q)
			S_IDLE: begin
				rd_en   = q_valid;
				rd_addr = sbe_pkg::AddrW'(sp_eff - 1'b1);
				if (q_valid && q_instr.op == sbe_pkg::OP_PUSH_IMM && sp_eff != Full) begin
					wr_en   = 1'b1;
					wr_addr = sbe_pkg::AddrW'(sp_eff);
					wr_data = {56'd0, q_instr.imm};
				end
			end
			S_RD1: begin
				rd_en   = 1'b1;
				rd_addr = sbe_pkg::AddrW'(sp_q - 2'd2);
			end
			S_EXEC: begin
				div_start = (ins_q.op == sbe_pkg::OP_DIV);
				if (ins_q.op == sbe_pkg::OP_ADD) begin
					wr_en = 1'b1; wr_data = l_q + r_q;
				end else if (ins_q.op == sbe_pkg::OP_SUB) begin
					wr_en = 1'b1; wr_data = l_q - r_q;
				end else if (ins_q.op == sbe_pkg::OP_MUL && prod_v_q) begin
					wr_en = 1'b1; wr_data = prod_q;
				end
				wr_addr = sbe_pkg::AddrW'(sp_q - 2'd2);
			end
			S_DIVW: begin
				wr_en   = div_fin;
				wr_addr = sbe_pkg::AddrW'(sp_q - 2'd2);
				wr_data = div_quo;
			end
			default: ;
		endcase
	end

	// 64x64 low product split into 32-bit partial products
	logic [63:0] pp_ll_q, pp_lh_q, pp_hl_q;
	logic [1:0]  mstep_q;

	always_ff @(posedge clk) begin
		pp_ll_q <= l_q[31:0] * r_q[31:0];
		pp_lh_q <= {l_q[31:0] * r_q[63:32], 32'd0};
		pp_hl_q <= {l_q[63:32] * r_q[31:0], 32'd0};
		prod_q  <= pp_ll_q + pp_lh_q + pp_hl_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (q_valid) ins_q <= q_instr;
			S_RD1:  r_q <= rdata_q;
			S_RD2:  l_q <= rdata_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			sp_q     <= '0;
			res_q    <= '0;
			ended_q  <= 1'b0;
			st_q     <= sbe_pkg::ST_RUN;
			prod_v_q <= 1'b0;
			mstep_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: if (q_valid) begin
					sp_q    <= sp_eff;
					ended_q <= 1'b0;
					if (ended_q) res_q <= '0;
					st_q <= sbe_pkg::ST_RUN;
					state_q <= S_OUT;
					case (q_instr.op)
						sbe_pkg::OP_PUSH_IMM: begin
							if (sp_eff == Full) begin
								st_q <= sbe_pkg::ST_OVER; ended_q <= 1'b1;
							end else sp_q <= sp_eff + 1'b1;
						end
						sbe_pkg::OP_ADD, sbe_pkg::OP_SUB, sbe_pkg::OP_MUL: begin
							if (sp_eff < 2) begin
								st_q <= sbe_pkg::ST_UNDER; ended_q <= 1'b1;
							end else state_q <= S_RD1;
						end
						sbe_pkg::OP_DIV, sbe_pkg::OP_POP_TO_RESULT: begin
							if (sp_eff == 0) begin
								st_q <= sbe_pkg::ST_UNDER; ended_q <= 1'b1;
							end else state_q <= S_RD1;
						end
						sbe_pkg::OP_DONE: begin
							st_q <= sbe_pkg::ST_DONE; ended_q <= 1'b1;
						end
						default: begin
							st_q <= sbe_pkg::ST_UNKNOWN; ended_q <= 1'b1;
						end
					endcase
				end
				S_RD1: begin
					if (ins_q.op == sbe_pkg::OP_POP_TO_RESULT) begin
						res_q   <= rdata_q;
						sp_q    <= sp_q - 1'b1;
						state_q <= S_OUT;
					end else if (ins_q.op == sbe_pkg::OP_DIV && rdata_q == '0) begin
						sp_q    <= sp_q - 1'b1;
						st_q    <= sbe_pkg::ST_DIV0;
						ended_q <= 1'b1;
						state_q <= S_OUT;
					end else if (ins_q.op == sbe_pkg::OP_DIV && sp_q < 2) begin
						sp_q    <= sp_q - 1'b1;
						st_q    <= sbe_pkg::ST_UNDER;
						ended_q <= 1'b1;
						state_q <= S_OUT;
					end else state_q <= S_RD2;
				end
				S_RD2: begin
					state_q  <= S_EXEC;
					prod_v_q <= 1'b0;
					mstep_q  <= '0;
				end
				S_EXEC: begin
					if (ins_q.op == sbe_pkg::OP_DIV) state_q <= S_DIVW;
					else if (ins_q.op == sbe_pkg::OP_MUL && !prod_v_q) begin
						mstep_q <= mstep_q + 2'd1;
						if (mstep_q == 2'd2) prod_v_q <= 1'b1;
					end else begin
						sp_q    <= sp_q - 1'b1;
						state_q <= S_OUT;
					end
				end
				S_DIVW: if (div_fin) begin
					sp_q    <= sp_q - 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/stack_bytecode_executor.sv]
// pushi, done, unknown and underflow are seen at decode in S_IDLE; pop_res and the
// divide errors end in S_RD1; add/sub pass S_RD2 and S_EXEC, mul waits in S_EXEC
// for its product, div in S_DIVW for 64 steps of a restoring divider; one item at a
// time in the execute unit, and a two-entry queue in front keeps accepting while an
// item executes, until full; the stack memory has one read and one write port
// reset: arst_n clears stack pointer, result register, queue and control state
module stack_bytecode_executor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid,
	output logic        ready,
	input  logic [7:0]  func,
	input  logic [7:0]  imm,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [63:0] result_value,
	output logic [8:0]  depth
);
	logic            q_valid, q_ready;
	sbe_pkg::instr_t q_instr;

	sbe_front u_front (
		.clk(clk), .arst_n(arst_n), .valid(valid), .ready(ready),
		.func(func), .imm(imm),
		.q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr)
	);

	sbe_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_instr(q_instr),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .result_value(result_value), .depth(depth)
	);

	a_depth_max: assert property (@(posedge clk) disable iff (!arst_n)
		depth <= 9'(sbe_pkg::StackDepth)) else $error("depth beyond stack");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= sbe_pkg::ST_OVER) else $error("bad status");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !q_ready) else $error("took item while result pending");
endmodule
